// ===== hdl/pdta_pkg.sv =====
// ----------------------------------------------------------------------------
// pdta_pkg
// Shared types, constants and calendar helpers for the packed date-time adder.
// ----------------------------------------------------------------------------
package pdta_pkg;

    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 32;

    localparam int unsigned DIV_XW    = 17;
    localparam int unsigned DIV_QW    = 14;
    localparam int unsigned DIV_DW    = 6;
    localparam int unsigned DIV_SHIFT = 17;

    localparam logic [DIV_QW-1:0] RECIP_12 = DIV_QW'((1 << DIV_SHIFT) / 12);
    localparam logic [DIV_QW-1:0] RECIP_24 = DIV_QW'((1 << DIV_SHIFT) / 24);
    localparam logic [DIV_QW-1:0] RECIP_28 = DIV_QW'((1 << DIV_SHIFT) / 28);
    localparam logic [DIV_QW-1:0] RECIP_29 = DIV_QW'((1 << DIV_SHIFT) / 29);
    localparam logic [DIV_QW-1:0] RECIP_30 = DIV_QW'((1 << DIV_SHIFT) / 30);
    localparam logic [DIV_QW-1:0] RECIP_31 = DIV_QW'((1 << DIV_SHIFT) / 31);
    localparam logic [DIV_QW-1:0] RECIP_60 = DIV_QW'((1 << DIV_SHIFT) / 60);

    localparam logic [DIV_DW-1:0] DIV_BY_12 = 6'd12;
    localparam logic [DIV_DW-1:0] DIV_BY_24 = 6'd24;
    localparam logic [DIV_DW-1:0] DIV_BY_60 = 6'd60;

    localparam logic [10:0] YEAR_BASE     = 11'd1898;
    localparam logic [10:0] LEAP_CENTURY  = 11'd1900;
    localparam logic [11:0] YEAR_BASE_W   = 12'd1898;
    localparam logic [11:0] YEAR_MIN      = 12'd1866;
    localparam logic [11:0] YEAR_MAX      = 12'd1930;
    localparam logic [3:0]  MONTH_LAST    = 4'd11;
    localparam logic [3:0]  MONTHS_YEAR   = 4'd12;

    typedef enum logic [2:0] {
        PH_SEC,
        PH_MIN,
        PH_HOUR,
        PH_DAY,
        PH_MON
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   div_est;
        logic   div_fix;
        logic   div_apply;
        logic   wrap;
        logic   day_chk;
        logic   year_wr;
        logic   pack;
        logic   out_load;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic zero_in;
        logic day_gt_len;
    } status_t;

    function automatic logic [DIV_QW-1:0] recip(input logic [DIV_DW-1:0] d);
        logic [DIV_QW-1:0] m;
        case (d)
            6'd12:   m = RECIP_12;
            6'd24:   m = RECIP_24;
            6'd28:   m = RECIP_28;
            6'd29:   m = RECIP_29;
            6'd30:   m = RECIP_30;
            6'd31:   m = RECIP_31;
            6'd60:   m = RECIP_60;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [10:0] decode_year(input logic [31:0] w);
        logic [10:0] mag;
        mag = 11'(w[30:26]);
        return w[31] ? (YEAR_BASE - mag) : (YEAR_BASE + mag);
    endfunction

    // decoded years span 1867..1929, so 1900 is the only century to exclude
    function automatic logic is_leap(input logic [10:0] y);
        return (y[1:0] == 2'b00) && (y != LEAP_CENTURY);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   n = 5'd30;
            4'd1:                                      n = leap ? 5'd29 : 5'd28;
            default:                                   n = 5'd30;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/pdta_div.sv =====
// ----------------------------------------------------------------------------
// pdta_div
// Two-step divider by a small constant: reciprocal estimate, then correction.
// ----------------------------------------------------------------------------
module pdta_div (
    input  logic                              aclk,
    input  logic                              est,
    input  logic                              fix,
    input  logic [pdta_pkg::DIV_XW-1:0]       x,
    input  logic [pdta_pkg::DIV_DW-1:0]       d,
    output logic [pdta_pkg::DIV_QW-1:0]       q,
    output logic [pdta_pkg::DIV_DW-1:0]       r
);

    localparam int unsigned PW = pdta_pkg::DIV_XW + pdta_pkg::DIV_QW;
    localparam int unsigned MW = pdta_pkg::DIV_QW + pdta_pkg::DIV_DW;

    logic [pdta_pkg::DIV_XW-1:0] x_reg;
    logic [pdta_pkg::DIV_DW-1:0] d_reg;
    logic [pdta_pkg::DIV_QW-1:0] est_reg;
    logic [pdta_pkg::DIV_QW-1:0] q_reg;
    logic [pdta_pkg::DIV_DW-1:0] r_reg;

    logic [PW-1:0]               prod_est;
    logic [MW-1:0]               prod_qd;
    logic [pdta_pkg::DIV_XW-1:0] rem;
    logic                        over;

    assign prod_est = PW'(x) * PW'(pdta_pkg::recip(d));
    assign prod_qd  = MW'(est_reg) * MW'(d_reg);
    assign rem      = x_reg - pdta_pkg::DIV_XW'(prod_qd);
    assign over     = rem >= pdta_pkg::DIV_XW'(d_reg);

    always_ff @(posedge aclk) begin
        if (est) begin
            x_reg   <= x;
            d_reg   <= d;
            est_reg <= prod_est[PW-1:pdta_pkg::DIV_SHIFT];
        end
        if (fix) begin
            if (over) begin
                q_reg <= est_reg + 1'b1;
                r_reg <= pdta_pkg::DIV_DW'(rem - pdta_pkg::DIV_XW'(d_reg));
            end else begin
                q_reg <= est_reg;
                r_reg <= pdta_pkg::DIV_DW'(rem);
            end
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

// ===== hdl/pdta_dp.sv =====
// ----------------------------------------------------------------------------
// pdta_dp
// Datapath: field registers, carry accumulators, divider and word assembly.
// ----------------------------------------------------------------------------
module pdta_dp (
    input  logic                  aclk,
    input  pdta_pkg::cmd_t        cmd,
    output pdta_pkg::status_t     status,
    input  logic [31:0]           packed_time,
    input  logic [15:0]           add_seconds,
    input  logic [15:0]           add_minutes,
    input  logic [15:0]           add_hours,
    input  logic [11:0]           add_days,
    input  logic [11:0]           add_months,
    input  logic [5:0]            add_years,
    input  logic                  hold_year,
    output logic [31:0]           new_time
);

    logic [31:0] w_reg;
    logic [31:0] m_data_reg;
    logic [pdta_pkg::DIV_XW-1:0] acc_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [12:0] day_reg;
    logic [3:0]  month_reg;
    logic [10:0] year_reg;
    logic [15:0] am_reg;
    logic [15:0] ah_reg;
    logic [11:0] ad_reg;
    logic [12:0] amo_reg;
    logic [8:0]  ay_reg;
    logic        hold_reg;

    logic [pdta_pkg::DIV_DW-1:0] div_d;
    logic [pdta_pkg::DIV_QW-1:0] div_q;
    logic [pdta_pkg::DIV_DW-1:0] div_r;
    logic [4:0]  len_cur;
    logic [4:0]  len_pack;
    logic [11:0] year_new;
    logic [11:0] year_mag;
    logic        year_ok;
    logic        year_neg;

    assign len_cur  = pdta_pkg::month_days(month_reg, pdta_pkg::is_leap(year_reg));
    assign len_pack = pdta_pkg::month_days(w_reg[25:22],
                          pdta_pkg::is_leap(pdta_pkg::decode_year(w_reg)));

    assign status.zero_in    = (add_seconds == '0) && (add_minutes == '0) &&
                               (add_hours == '0) && (add_days == '0) &&
                               (add_months == '0) && (add_years == '0);
    assign status.day_gt_len = day_reg > 13'(len_cur);

    always_comb begin
        case (cmd.phase)
            pdta_pkg::PH_SEC:  div_d = pdta_pkg::DIV_BY_60;
            pdta_pkg::PH_MIN:  div_d = pdta_pkg::DIV_BY_60;
            pdta_pkg::PH_HOUR: div_d = pdta_pkg::DIV_BY_24;
            pdta_pkg::PH_DAY:  div_d = pdta_pkg::DIV_DW'(len_cur);
            pdta_pkg::PH_MON:  div_d = pdta_pkg::DIV_BY_12;
            default:           div_d = pdta_pkg::DIV_BY_12;
        endcase
    end

    always_comb begin
        year_new = hold_reg ? 12'(year_reg) : (12'(year_reg) + 12'(ay_reg));
        year_ok  = (year_new >= pdta_pkg::YEAR_MIN) && (year_new <= pdta_pkg::YEAR_MAX);
        year_neg = year_new < pdta_pkg::YEAR_BASE_W;
        year_mag = year_neg ? (pdta_pkg::YEAR_BASE_W - year_new)
                            : (year_new - pdta_pkg::YEAR_BASE_W);
    end

    pdta_div u_div (
        .aclk (aclk),
        .est  (cmd.div_est),
        .fix  (cmd.div_fix),
        .x    (acc_reg),
        .d    (div_d),
        .q    (div_q),
        .r    (div_r)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg     <= packed_time;
            acc_reg   <= pdta_pkg::DIV_XW'(packed_time[5:0]) +
                         pdta_pkg::DIV_XW'(add_seconds);
            min_reg   <= packed_time[11:6];
            hour_reg  <= packed_time[16:12];
            day_reg   <= 13'(packed_time[21:17]);
            month_reg <= packed_time[25:22];
            year_reg  <= pdta_pkg::decode_year(packed_time);
            am_reg    <= add_minutes;
            ah_reg    <= add_hours;
            ad_reg    <= add_days;
            amo_reg   <= 13'(add_months);
            ay_reg    <= 9'(add_years);
            hold_reg  <= hold_year;
        end
        if (cmd.div_apply) begin
            case (cmd.phase)
                pdta_pkg::PH_SEC: begin
                    sec_reg <= div_r;
                    acc_reg <= pdta_pkg::DIV_XW'(min_reg) + pdta_pkg::DIV_XW'(am_reg) +
                               pdta_pkg::DIV_XW'(div_q);
                end
                pdta_pkg::PH_MIN: begin
                    min_reg <= div_r;
                    acc_reg <= pdta_pkg::DIV_XW'(hour_reg) + pdta_pkg::DIV_XW'(ah_reg) +
                               pdta_pkg::DIV_XW'(div_q);
                end
                pdta_pkg::PH_HOUR: begin
                    hour_reg <= 5'(div_r);
                    day_reg  <= day_reg + 13'(ad_reg) + 13'(div_q);
                end
                pdta_pkg::PH_DAY: begin
                    day_reg <= 13'(div_r) + 13'd1;
                    amo_reg <= amo_reg + 13'(div_q);
                    acc_reg <= pdta_pkg::DIV_XW'(month_reg) + pdta_pkg::DIV_XW'(amo_reg) +
                               pdta_pkg::DIV_XW'(div_q);
                end
                pdta_pkg::PH_MON: begin
                    month_reg <= 4'(div_r);
                    ay_reg    <= ay_reg + 9'(div_q);
                end
                default: begin
                end
            endcase
        end
        if (cmd.wrap) begin
            if (month_reg > pdta_pkg::MONTH_LAST && status.day_gt_len) begin
                day_reg   <= day_reg - 13'(len_cur);
                amo_reg   <= amo_reg + 13'd1;
                ay_reg    <= ay_reg + 9'd1;
                month_reg <= month_reg - pdta_pkg::MONTHS_YEAR;
            end
        end
        if (cmd.day_chk) begin
            if (status.day_gt_len) begin
                acc_reg <= pdta_pkg::DIV_XW'(day_reg - 13'd1);
            end else begin
                acc_reg <= pdta_pkg::DIV_XW'(month_reg) + pdta_pkg::DIV_XW'(amo_reg);
            end
        end
        if (cmd.year_wr) begin
            if (year_ok) begin
                w_reg[30:26] <= year_mag[4:0];
                w_reg[31]    <= year_neg;
            end
            w_reg[25:22] <= month_reg;
        end
        if (cmd.pack) begin
            if (day_reg != '0 && day_reg <= 13'(len_pack)) begin
                w_reg[21:17] <= day_reg[4:0];
            end
            w_reg[16:12] <= hour_reg;
            w_reg[11:6]  <= min_reg;
            w_reg[5:0]   <= sec_reg;
        end
        if (cmd.out_load) begin
            m_data_reg <= w_reg;
        end
    end

    assign new_time = m_data_reg;

endmodule

// ===== hdl/pdta_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdta_ctrl
// Sequencer: walks the carry chain through the shared divider, owns handshakes.
// ----------------------------------------------------------------------------
module pdta_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  pdta_pkg::status_t   status,
    output pdta_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EST,
        ST_FIX,
        ST_APPLY,
        ST_WRAP,
        ST_DAYCK,
        ST_YEAR,
        ST_PACK,
        ST_OUT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    pdta_pkg::phase_t  phase_reg;
    pdta_pkg::phase_t  phase_next;
    logic              s_tready_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.phase  = phase_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load = 1'b1;
                    if (status.zero_in) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_EST;
                        phase_next = pdta_pkg::PH_SEC;
                    end
                end
            end
            ST_EST: begin
                cmd.div_est = 1'b1;
                state_next  = ST_FIX;
            end
            ST_FIX: begin
                cmd.div_fix = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.div_apply = 1'b1;
                case (phase_reg)
                    pdta_pkg::PH_SEC: begin
                        phase_next = pdta_pkg::PH_MIN;
                        state_next = ST_EST;
                    end
                    pdta_pkg::PH_MIN: begin
                        phase_next = pdta_pkg::PH_HOUR;
                        state_next = ST_EST;
                    end
                    pdta_pkg::PH_HOUR: begin
                        state_next = ST_WRAP;
                    end
                    pdta_pkg::PH_DAY: begin
                        phase_next = pdta_pkg::PH_MON;
                        state_next = ST_EST;
                    end
                    pdta_pkg::PH_MON: begin
                        state_next = ST_YEAR;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = ST_DAYCK;
            end
            ST_DAYCK: begin
                cmd.day_chk = 1'b1;
                phase_next  = status.day_gt_len ? pdta_pkg::PH_DAY : pdta_pkg::PH_MON;
                state_next  = ST_EST;
            end
            ST_YEAR: begin
                cmd.year_wr = 1'b1;
                state_next  = ST_PACK;
            end
            ST_PACK: begin
                cmd.pack   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= pdta_pkg::PH_SEC;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            s_tready_reg <= state_next == ST_IDLE;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready_reg |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_start_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready_reg && !status.zero_in)
            |=> (state_reg == ST_EST && phase_reg == pdta_pkg::PH_SEC))
        else $error("accepted beat did not start the seconds carry");

    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result valid raised outside output state");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> state_reg == ST_OUT)
        else $error("pending result overwritten");

endmodule

// ===== hdl/packed_date_time_adder.sv =====
// ----------------------------------------------------------------------------
// packed_date_time_adder
// Sequence: each accepted beat makes four passes through the single shared
// reciprocal divider, five when the day count passes the month length, and
// none when all increments are zero; a new beat is accepted only once the
// sequencer is back in idle, and a result waits while an earlier one is held.
// Reset: synchronous active-low aresetn clears the sequencer, s_tready and m_tvalid.
// ----------------------------------------------------------------------------
module packed_date_time_adder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // packed_time[31:0], add_seconds[47:32], add_minutes[63:48], add_hours[79:64],
    // add_days[91:80], add_months[103:92], add_years[109:104], hold_year[110]
    input  logic [pdta_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // new_time[31:0]
    output logic [pdta_pkg::M_TDATA_W-1:0]      m_tdata
);

    pdta_pkg::cmd_t    cmd;
    pdta_pkg::status_t status;

    pdta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pdta_dp u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .packed_time (s_tdata[31:0]),
        .add_seconds (s_tdata[47:32]),
        .add_minutes (s_tdata[63:48]),
        .add_hours   (s_tdata[79:64]),
        .add_days    (s_tdata[91:80]),
        .add_months  (s_tdata[103:92]),
        .add_years   (s_tdata[109:104]),
        .hold_year   (s_tdata[110]),
        .new_time    (m_tdata)
    );

endmodule
